### sv/mast_pkg.sv
// shared types and constants of the mac address statistics table
package mast_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned PKT_W  = 32;
  localparam int unsigned BYTE_W = 64;
  localparam int unsigned DEV_W  = 7;

  typedef enum logic [1:0] {
    ST_SKIPPED = 2'd0,
    ST_UPDATED = 2'd1,
    ST_ADDED   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // one lookup travelling down the cell chain
  typedef struct packed {
    logic                valid;
    logic                done;
    status_e             status;
    logic [MAC_W-1:0]    addr;
    logic [LEN_W-1:0]    len;
    logic [PKT_W-1:0]    pkts;
    logic [BYTE_W-1:0]   bytes;
  } item_t;

endpackage

### sv/mast_if.sv
// valid/ready channel interfaces for lookup requests and results
interface mast_in_if import mast_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MAC_W-1:0]  mac_address;
  logic [LEN_W-1:0]  frame_length;

  modport source (output valid, output mac_address, output frame_length, input ready);
  modport sink   (input valid, input mac_address, input frame_length, output ready);
endinterface

interface mast_out_if import mast_pkg::*;;
  logic               valid;
  logic               ready;
  status_e            status;
  logic [PKT_W-1:0]   pkt_count;
  logic [BYTE_W-1:0]  byte_count;
  logic [DEV_W-1:0]   device_count;

  modport source (output valid, output status, output pkt_count, output byte_count,
                  output device_count, input ready);
  modport sink   (input valid, input status, input pkt_count, input byte_count,
                  input device_count, output ready);
endinterface

### sv/mast_cell.sv
// one table entry with its match, learn and counter update logic
module mast_cell import mast_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  item_t item_i,
  output item_t item_o,
  output logic  valid_o
);

  logic              ent_valid_q, ent_valid_d;
  logic [MAC_W-1:0]  ent_addr_q, ent_addr_d;
  logic [PKT_W-1:0]  ent_pkts_q, ent_pkts_d;
  logic [BYTE_W-1:0] ent_bytes_q, ent_bytes_d;
  item_t             item_q, item_d;
  logic              hit, claim;
  logic [PKT_W-1:0]  pkts_inc;
  logic [BYTE_W-1:0] bytes_sum;

  assign hit   = ent_valid_q && item_i.valid && !item_i.done && (ent_addr_q == item_i.addr);
  // entries fill from cell 0 upward, so the first empty cell means a miss
  assign claim = !ent_valid_q && item_i.valid && !item_i.done;

  assign pkts_inc  = ent_pkts_q + PKT_W'(1);
  assign bytes_sum = ent_bytes_q + BYTE_W'(item_i.len);

  always_comb begin
    item_d      = item_i;
    ent_valid_d = ent_valid_q;
    ent_addr_d  = ent_addr_q;
    ent_pkts_d  = ent_pkts_q;
    ent_bytes_d = ent_bytes_q;
    priority if (hit) begin
      ent_pkts_d    = pkts_inc;
      ent_bytes_d   = bytes_sum;
      item_d.done   = 1'b1;
      item_d.status = ST_UPDATED;
      item_d.pkts   = pkts_inc;
      item_d.bytes  = bytes_sum;
    end else if (claim) begin
      ent_valid_d   = 1'b1;
      ent_addr_d    = item_i.addr;
      ent_pkts_d    = PKT_W'(1);
      ent_bytes_d   = BYTE_W'(item_i.len);
      item_d.done   = 1'b1;
      item_d.status = ST_ADDED;
      item_d.pkts   = PKT_W'(1);
      item_d.bytes  = BYTE_W'(item_i.len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      item_q      <= '0;
    end else if (adv_i) begin
      ent_valid_q <= ent_valid_d;
      item_q      <= item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ent_addr_q  <= ent_addr_d;
      ent_pkts_q  <= ent_pkts_d;
      ent_bytes_q <= ent_bytes_d;
    end
  end

  assign item_o  = item_q;
  assign valid_o = ent_valid_q;

endmodule

### sv/mast_out_stage.sv
// result register, table-full decision and learned device counter
module mast_out_stage import mast_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  output logic        adv_o,
  mast_out_if.source  out_o
);

  logic              valid_q, valid_d;
  status_e           status_q, status_d;
  logic [PKT_W-1:0]  pkts_q, pkts_d;
  logic [BYTE_W-1:0] bytes_q, bytes_d;
  logic [DEV_W-1:0]  dev_q, dev_d;
  logic [DEV_W-1:0]  learned_q, learned_d;
  logic              adv;

  assign adv = !valid_q || out_o.ready;

  always_comb begin
    valid_d   = item_i.valid;
    status_d  = item_i.status;
    pkts_d    = item_i.pkts;
    bytes_d   = item_i.bytes;
    learned_d = learned_q;
    // a word that passed every cell unmatched found no free entry
    if (!item_i.done) begin
      status_d = ST_FULL;
      pkts_d   = '0;
      bytes_d  = '0;
    end
    if (item_i.valid && item_i.done && item_i.status == ST_ADDED) begin
      learned_d = learned_q + DEV_W'(1);
    end
    dev_d = learned_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      learned_q <= '0;
    end else if (adv) begin
      valid_q <= valid_d;
      if (item_i.valid) begin
        learned_q <= learned_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && item_i.valid) begin
      status_q <= status_d;
      pkts_q   <= pkts_d;
      bytes_q  <= bytes_d;
      dev_q    <= dev_d;
    end
  end

  assign adv_o              = adv;
  assign out_o.valid        = valid_q;
  assign out_o.status       = status_q;
  assign out_o.pkt_count    = pkts_q;
  assign out_o.byte_count   = bytes_q;
  assign out_o.device_count = dev_q;

endmodule

### sv/mac_address_stats_table.sv
// top level: learns mac addresses and keeps per-address packet and byte counts
// Each lookup word walks a chain of TABLE_ENTRIES cells, one cell per clock while the chain
// advances, each cell holding one learned address with its counters; a word's result is
// presented from the result register behind the last cell. The chain moves as a whole, so a new
// word is taken every clock unless the result register is held by the consumer, and a
// word always sees every update made by the words ahead of it. Entries fill from cell 0
// upward and are never freed; the table is empty right after reset with no clearing
// sweep. The device count is 7 bits wide and wraps for tables above 127 entries.
module mac_address_stats_table import mast_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mast_in_if.sink    in_i,
  mast_out_if.source out_o
);

  item_t                    item_w [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic                     adv;

  assign in_i.ready = adv;

  always_comb begin
    item_w[0].valid  = in_i.valid;
    item_w[0].done   = (in_i.mac_address == '0);
    item_w[0].status = ST_SKIPPED;
    item_w[0].addr   = in_i.mac_address;
    item_w[0].len    = in_i.frame_length;
    item_w[0].pkts   = '0;
    item_w[0].bytes  = '0;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    mast_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .item_i  (item_w[k]),
      .item_o  (item_w[k+1]),
      .valid_o (entry_valid[k])
    );
  end

  mast_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_w[TABLE_ENTRIES]),
    .adv_o  (adv),
    .out_o  (out_o)
  );

  // learned entries stay packed at the low end of the chain
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid[TABLE_ENTRIES-1:1] & ~entry_valid[TABLE_ENTRIES-2:0]) == '0)
    else $error("learned entries not contiguous");

  a_added_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_ADDED) |->
      (out_o.pkt_count == PKT_W'(1) && out_o.byte_count[BYTE_W-1:LEN_W] == '0))
    else $error("new entry counts not started at this frame");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_SKIPPED || out_o.status == ST_FULL)) |->
      (out_o.pkt_count == '0 && out_o.byte_count == '0))
    else $error("counts reported without a matched entry");

endmodule

### tb/mac_address_stats_table_tb.sv
// testbench of the mac address statistics table: directed and random words against an in-order table predictor
`timescale 1ns / 100ps

module mac_address_stats_table_tb import mast_pkg::*;;

  localparam int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned POOL_SIZE     = 96;
  localparam int unsigned RANDOM_WORDS  = 640;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [LEN_W-1:0] len;
  } frame_t;

  typedef struct packed {
    status_e           status;
    logic [PKT_W-1:0]  pkts;
    logic [BYTE_W-1:0] bytes;
    logic [DEV_W-1:0]  devices;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mast_in_if  in_if ();
  mast_out_if out_if ();

  mac_address_stats_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted table contents
  logic              known_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]  known_mac   [TABLE_ENTRIES];
  logic [PKT_W-1:0]  known_pkts  [TABLE_ENTRIES];
  logic [BYTE_W-1:0] known_bytes [TABLE_ENTRIES];
  logic [DEV_W-1:0]  known_devices;

  frame_t  pending_frames[$];
  result_t expected_results[$];
  int      mismatch_count = 0;
  int      frames_taken   = 0;
  int      cycle_count    = 0;
  logic    holding_off    = 1'b0;

  int burst_left;
  int gap_left;
  int stall_mode;
  int mode_left;

  function automatic void learn_and_count(input logic [MAC_W-1:0] mac,
                                          input logic [LEN_W-1:0] len);
    result_t r;
    int      hit;
    int      free_idx;
    hit      = -1;
    free_idx = -1;
    r.status = ST_SKIPPED;
    r.pkts   = '0;
    r.bytes  = '0;
    if (mac != '0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (known_valid[i]) begin
          if (hit < 0 && known_mac[i] == mac) hit = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit >= 0) begin
        known_pkts[hit]  = known_pkts[hit] + 1'b1;
        known_bytes[hit] = known_bytes[hit] + BYTE_W'(len);
        r.status = ST_UPDATED;
        r.pkts   = known_pkts[hit];
        r.bytes  = known_bytes[hit];
      end else if (free_idx >= 0) begin
        known_valid[free_idx] = 1'b1;
        known_mac[free_idx]   = mac;
        known_pkts[free_idx]  = PKT_W'(1);
        known_bytes[free_idx] = BYTE_W'(len);
        known_devices = known_devices + 1'b1;
        r.status = ST_ADDED;
        r.pkts   = PKT_W'(1);
        r.bytes  = BYTE_W'(len);
      end else begin
        r.status = ST_FULL;
      end
    end
    r.devices = known_devices;
    expected_results.push_back(r);
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [MAC_W-1:0] m;
    do m = MAC_W'({$urandom, $urandom}); while (m == '0);
    return m;
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // sender: bursts of words with random gaps, holds a word until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.mac_address  <= '0;
      in_if.frame_length <= '0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        learn_and_count(in_if.mac_address, in_if.frame_length);
        frames_taken++;
      end
      if (in_if.valid && !in_if.ready) begin
        // word still waiting, keep it on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_frames.size() > 0) begin
        in_if.valid        <= 1'b1;
        in_if.mac_address  <= pending_frames[0].mac;
        in_if.frame_length <= pending_frames[0].len;
        void'(pending_frames.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode every so often
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   = 0;
      mode_left    = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_if.ready <= !holding_off;
        1:       out_if.ready <= !holding_off && ($urandom_range(0, 3) != 0);
        default: out_if.ready <= !holding_off && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // long hold-off so the held result stalls the lookup chain and backs up the input
  initial begin
    do @(posedge clk_i); while (frames_taken < 150);
    holding_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status  = out_if.status;
      got.pkts    = out_if.pkt_count;
      got.bytes   = out_if.byte_count;
      got.devices = out_if.device_count;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %s pkts %0d bytes %0d devices %0d",
                   got.status.name(), got.pkts, got.bytes, got.devices);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %s pkts %0d bytes %0d devices %0d, got %s %0d %0d %0d",
                     want.status.name(), want.pkts, want.bytes, want.devices,
                     got.status.name(), got.pkts, got.bytes, got.devices);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** mac_address_stats_table: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [MAC_W-1:0] addr_pool [POOL_SIZE];
    frame_t           f;
    int               pick;
    rst_ni              = 1'b0;
    known_devices       = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      known_valid[i] = 1'b0;
      known_mac[i]   = '0;
      known_pkts[i]  = '0;
      known_bytes[i] = '0;
    end

    // directed: zero address, extreme addresses and lengths, hits and misses
    pending_frames.push_back('{'0, '0});
    pending_frames.push_back('{'0, '1});
    pending_frames.push_back('{'1, '1});
    pending_frames.push_back('{'1, '1});
    pending_frames.push_back('{48'h0000_0000_0001, '0});
    pending_frames.push_back('{48'h0000_0000_0001, 16'h0001});
    pending_frames.push_back('{48'h8000_0000_0000, 16'h8000});
    pending_frames.push_back('{'0, 16'h0001});
    pending_frames.push_back('{'1, '0});
    pending_frames.push_back('{48'hAAAA_AAAA_AAAA, 16'h5555});
    pending_frames.push_back('{48'h5555_5555_5555, 16'hAAAA});
    pending_frames.push_back('{48'hAAAA_AAAA_AAAA, 16'hAAAA});
    pending_frames.push_back('{48'h8000_0000_0000, '1});
    pending_frames.push_back('{48'h0000_0000_0001, '1});

    // pool larger than the table, so it fills and later misses report full
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = random_mac();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       f.mac = '0;
      else if (pick < 14) f.mac = random_mac();
      else                f.mac = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      f.len = random_len();
      pending_frames.push_back(f);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_frames.size() > 0 || in_if.valid || expected_results.size() > 0);
    repeat (TABLE_ENTRIES + 20) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** mac_address_stats_table: PASSED **");
    end else begin
      $display("** mac_address_stats_table: FAILED **");
    end
    $finish;
  end

endmodule
